// ===== src/scp_pkg.sv =====
// Shared types and constants for the stepper command parser.
// Used by scp_ctrl, scp_datapath and stepper_command_parser_top; no dependencies.
`default_nettype none

package scp_pkg;

    // Scan geometry
    localparam int MAX_SCAN_STEPS = 64;
    localparam int MICROSTEPS     = 2048;
    localparam int MIN_SCAN_STEPS = 2;

    localparam int CNT_W  = 6;                      // step counter
    localparam int LIM_W  = 7;                      // steps per scan
    localparam int SIZE_W = 11;                     // step size field
    localparam int DIV_BITS = $clog2(MICROSTEPS) + 1; // quotient bits of 2048 / limit
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam int REM_W  = LIM_W - 1;              // remainder stays below the limit

    // Characters
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    // Result beat layout in m_tdata (finished travels as tlast)
    localparam int OUT_ACK_LSB    = 0;
    localparam int OUT_STEP_LSB   = 1;
    localparam int OUT_SIZE_LSB   = 2;
    localparam int OUT_STAT_LSB   = OUT_SIZE_LSB + SIZE_W;
    localparam int OUT_CNT_LSB    = OUT_STAT_LSB + 2;
    localparam int OUT_LIM_LSB    = OUT_CNT_LSB + CNT_W;
    localparam int OUT_USED_W     = OUT_LIM_LSB + LIM_W;
    localparam int OUT_DATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        SET_NONE  = 2'd0,
        SET_OK    = 2'd1,
        SET_RANGE = 2'd2,
        SET_BUSY  = 2'd3
    } set_status_t;

    typedef enum logic [12:0] {
        PS_IDLE = 13'b0000000000001,
        PS_S    = 13'b0000000000010,
        PS_ST   = 13'b0000000000100,
        PS_STE  = 13'b0000000001000,
        PS_M    = 13'b0000000010000,
        PS_MA   = 13'b0000000100000,
        PS_MAX  = 13'b0000001000000,
        PS_EQ   = 13'b0000010000000,
        PS_D1   = 13'b0000100000000,
        PS_R    = 13'b0001000000000,
        PS_RE   = 13'b0010000000000,
        PS_RES  = 13'b0100000000000,
        PS_RESE = 13'b1000000000000
    } parse_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;   // latch the input beat
        logic exec;      // parse / update counters, start divider on a step
        logic div_run;   // one divider iteration
        logic out_load;  // move result into the output register
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic step_now;  // item being executed takes a step
        logic div_done;  // last divider iteration this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/scp_ctrl.sv =====
// Sequencer for the stepper command parser: handshakes and step ordering.
// Depends on scp_pkg.
`default_nettype none

module scp_ctrl
    import scp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_EXEC = 4'b0010,
        C_DIV  = 4'b0100,
        C_DONE = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == C_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            C_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = C_EXEC;
                end
            end
            C_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.step_now ? C_DIV : C_DONE;
            end
            C_DIV: begin
                cmd.div_run = 1'b1;
                if (status.div_done) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/scp_datapath.sv =====
// Datapath of the stepper command parser: command recognizer, step counter,
// step limit, bit-serial 2048 / limit divider and result register. Depends on scp_pkg.
`default_nettype none

module scp_datapath
    import scp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              func,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic                   ack,
    output logic                   step_request,
    output logic [SIZE_W-1:0]      step_size,
    output logic [1:0]             set_status,
    output logic                   finished,
    output logic [CNT_W-1:0]       step_count,
    output logic [LIM_W-1:0]       step_limit
);

    // Latched input beat
    logic       func_reg;
    logic [7:0] byte_reg;

    // Architectural state
    parse_state_t       parse_reg, parse_next;
    logic [3:0]         digit_reg, digit_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIM_W-1:0]   limit_reg, limit_next;

    // Per-item flags
    logic        res_ack_reg, res_ack_next;
    logic        res_step_reg, res_step_next;
    set_status_t res_stat_reg, res_stat_next;
    logic        res_fin_reg, res_fin_next;

    // Divider
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_BITS-1:0]  dvd_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [LIM_W-1:0]     trial;
    logic                 trial_ge;

    // Output register payload
    logic                 out_ack_reg;
    logic                 out_step_reg;
    logic [SIZE_W-1:0]    out_size_reg;
    set_status_t          out_stat_reg;
    logic                 out_fin_reg;
    logic [CNT_W-1:0]     out_cnt_reg;
    logic [LIM_W-1:0]     out_lim_reg;

    logic             is_digit;
    logic [3:0]       digit_val;
    logic [LIM_W-1:0] step_inc;
    logic             step_wrap;
    logic [LIM_W-1:0] max_value;

    assign is_digit  = (byte_reg inside {[CH_0:CH_9]});
    assign digit_val = 4'(byte_reg - CH_0);
    assign step_inc  = {1'b0, count_reg} + LIM_W'(1);
    assign step_wrap = (step_inc >= limit_reg);
    assign max_value = is_digit ? (LIM_W'(digit_reg) * LIM_W'(10) + LIM_W'(digit_val))
                                : LIM_W'(digit_reg);

    always_comb begin
        parse_next    = parse_reg;
        digit_next    = digit_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        res_ack_next  = 1'b0;
        res_step_next = 1'b0;
        res_stat_next = SET_NONE;
        res_fin_next  = 1'b0;

        if (func_reg) begin
            res_step_next = 1'b1;
        end else begin
            case (parse_reg)
                PS_S:   if (byte_reg == CH_T) parse_next = PS_ST;
                PS_ST:  if (byte_reg == CH_E) parse_next = PS_STE;
                PS_STE: begin
                    if (byte_reg == CH_P) begin
                        parse_next    = PS_IDLE;
                        res_step_next = 1'b1;
                        res_ack_next  = 1'b1;
                    end
                end
                PS_M:   if (byte_reg == CH_A)  parse_next = PS_MA;
                PS_MA:  if (byte_reg == CH_X)  parse_next = PS_MAX;
                PS_MAX: if (byte_reg == CH_EQ) parse_next = PS_EQ;
                PS_EQ: begin
                    if (is_digit) begin
                        digit_next = digit_val;
                        parse_next = PS_D1;
                    end
                end
                PS_D1: begin
                    parse_next   = PS_IDLE;
                    res_ack_next = 1'b1;
                    if (max_value < LIM_W'(MIN_SCAN_STEPS) ||
                        max_value > LIM_W'(MAX_SCAN_STEPS)) begin
                        res_stat_next = SET_RANGE;
                    end else if (count_reg != '0) begin
                        res_stat_next = SET_BUSY;
                    end else begin
                        res_stat_next = SET_OK;
                        limit_next    = max_value;
                    end
                end
                PS_R:   if (byte_reg == CH_E) parse_next = PS_RE;
                PS_RE:  if (byte_reg == CH_S) parse_next = PS_RES;
                PS_RES: if (byte_reg == CH_E) parse_next = PS_RESE;
                PS_RESE: begin
                    if (byte_reg == CH_T) begin
                        parse_next   = PS_IDLE;
                        count_next   = '0;
                        res_ack_next = 1'b1;
                    end
                end
                default: begin
                    // idle and unreachable codes
                    if (byte_reg == CH_S) begin
                        parse_next = PS_S;
                    end else if (byte_reg == CH_M) begin
                        parse_next = PS_M;
                    end else if (byte_reg == CH_R) begin
                        parse_next = PS_R;
                    end else begin
                        parse_next = PS_IDLE;
                    end
                end
            endcase
        end

        if (res_step_next) begin
            res_fin_next = step_wrap;
            count_next   = step_wrap ? '0 : step_inc[CNT_W-1:0];
        end
    end

    assign status.step_now = res_step_next;
    assign status.div_done = (div_cnt_reg == DIV_CNT_W'(DIV_BITS - 1));

    // Restoring divider step; limit does not change while a step is in flight
    assign trial    = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign trial_ge = (trial >= limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg <= PS_IDLE;
            digit_reg <= '0;
            count_reg <= '0;
            limit_reg <= LIM_W'(MAX_SCAN_STEPS);
        end else if (cmd.exec) begin
            parse_reg <= parse_next;
            digit_reg <= digit_next;
            count_reg <= count_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= func;
            byte_reg <= rx_byte;
        end
        if (cmd.exec) begin
            res_ack_reg  <= res_ack_next;
            res_step_reg <= res_step_next;
            res_stat_reg <= res_stat_next;
            res_fin_reg  <= res_fin_next;
            rem_reg      <= '0;
            dvd_reg      <= DIV_BITS'(MICROSTEPS);
            quo_reg      <= '0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_run) begin
            rem_reg     <= trial_ge ? REM_W'(trial - limit_reg) : trial[REM_W-1:0];
            dvd_reg     <= {dvd_reg[DIV_BITS-2:0], 1'b0};
            quo_reg     <= {quo_reg[DIV_BITS-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.out_load) begin
            out_ack_reg  <= res_ack_reg;
            out_step_reg <= res_step_reg;
            out_size_reg <= res_step_reg ? quo_reg[SIZE_W-1:0] : '0;
            out_stat_reg <= res_stat_reg;
            out_fin_reg  <= res_fin_reg;
            out_cnt_reg  <= count_reg;
            out_lim_reg  <= limit_reg;
        end
    end

    assign ack          = out_ack_reg;
    assign step_request = out_step_reg;
    assign step_size    = out_size_reg;
    assign set_status   = out_stat_reg;
    assign finished     = out_fin_reg;
    assign step_count   = out_cnt_reg;
    assign step_limit   = out_lim_reg;

endmodule

`default_nettype wire

// ===== src/stepper_command_parser_top.sv =====
// Top level of the stepper command parser: controller plus datapath.
// Depends on scp_pkg, scp_ctrl and scp_datapath.
//
//  channel  dir  tdata (low bit first)                                  tuser  tlast
//  s_       in   rx_byte[7:0]                                           func   -
//  m_       out  ack, step_request, step_size[10:0], set_status[1:0],   -      finished
//                step_count[5:0], step_limit[6:0], zero pad to 32 bits
//
// One item at a time. A command byte that takes no step goes from accept
// through the exec state to the result; a step (STEP or button) also runs
// the bit-serial divider that forms 2048 / step limit.
// Synchronous active-low reset: parser idle, counter 0, limit 64, no result pending.
// A new beat is taken while the previous result waits in the output register;
// a stalled m_ side holds the next result back only at its last cycle.
`default_nettype none

module stepper_command_parser_top
    import scp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // rx_byte[7:0]
    input  wire logic                  s_tuser,   // func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // ack, step_request, step_size,
                                                  // set_status, step_count, step_limit
    output logic                       m_tlast    // finished
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic              ack;
    logic              step_request;
    logic [SIZE_W-1:0] step_size;
    logic [1:0]        set_status;
    logic              finished;
    logic [CNT_W-1:0]  step_count;
    logic [LIM_W-1:0]  step_limit;

    scp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scp_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rx_byte      (s_tdata),
        .func         (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .ack          (ack),
        .step_request (step_request),
        .step_size    (step_size),
        .set_status   (set_status),
        .finished     (finished),
        .step_count   (step_count),
        .step_limit   (step_limit)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, step_limit, step_count,
                      set_status, step_size, step_request, ack};
    assign m_tlast = finished;

    // Controller issues at most one datapath command per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.exec, cmd.div_run, cmd.out_load}))
        else $error("overlapping datapath commands");

    // Reported limit always in the legal range, counter always below it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (step_limit >= LIM_W'(MIN_SCAN_STEPS)) &&
                     (step_limit <= LIM_W'(MAX_SCAN_STEPS)) &&
                     ({1'b0, step_count} < step_limit))
        else $error("step counter or limit out of range");

    // A step carries the exact microstep size for the limit in force
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && step_request) |->
            (32'(step_size) * 32'(step_limit) <= 32'(MICROSTEPS)) &&
            (32'(step_size) * 32'(step_limit) + 32'(step_limit) > 32'(MICROSTEPS)))
        else $error("step size does not match step limit");

    // Non-step results carry no size and never finish a scan; MAX results are acked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !step_request) |->
            (step_size == '0) && !finished && ((set_status == SET_NONE) || ack))
        else $error("inconsistent non-step result");

endmodule

`default_nettype wire
